// ----- rtl/pc_pkg.sv -----
// Shared types and constants for the path canonicalizer.
package pc_pkg;

  localparam int COUNT_WIDTH_DEF = 13;
  localparam int LIMIT_W         = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1024;

  localparam int STATUS_W    = 2;
  localparam int MAX_RES     = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                path_done;
    logic                byte_valid;
    logic [7:0]          out_byte;
  } result_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]       cnt;
    result_t [MAX_RES-1:0]      res;
  } push_t;

endpackage

// ----- rtl/pc_parser.sv -----
// Input register, parse state and the per-byte canonicalization step.
module pc_parser #(
  parameter int COUNT_WIDTH = pc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic [pc_pkg::LIMIT_W-1:0] limit_i,
  input  logic                       room_i,
  output pc_pkg::push_t              push_o
);
  import pc_pkg::*;

  localparam logic [2:0] MODE_SEP  = 3'd0;
  localparam logic [2:0] MODE_DOT1 = 3'd1;
  localparam logic [2:0] MODE_DOT2 = 3'd2;
  localparam logic [2:0] MODE_SEG  = 3'd3;
  localparam logic [2:0] MODE_SKIP = 3'd4;

  localparam logic [STATUS_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ERR_PARENT = 2'd1;
  localparam logic [STATUS_W-1:0] ERR_LONG   = 2'd2;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam int EXT_W = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 3;
  localparam logic [EXT_W-1:0] CNT_MAX = (EXT_W'(1) << COUNT_WIDTH) - EXT_W'(1);

  logic                   vld_q, vld_d;
  logic [7:0]             byte_q;
  logic [2:0]             mode_q, mode_d;
  logic [STATUS_W-1:0]    err_q, err_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   consume;

  logic [2:0]             mode;
  logic                   is_end;
  logic                   parent_fail;
  logic                   opening;
  logic [1:0]             dots;
  logic [RES_CNT_W-1:0]   req_n;
  logic [RES_CNT_W-1:0]   fit_n;
  logic [RES_CNT_W-1:0]   emit_n;
  logic                   short_fit;
  logic [MAX_RES-1:0][7:0] seq;
  logic [MAX_RES-1:0]     fits;
  logic [STATUS_W-1:0]    err_fin;
  logic [EXT_W-1:0]       cnt_ext;
  logic [EXT_W-1:0]       lim_ext;
  pc_pkg::push_t          push;

  assign consume    = vld_q && room_i;
  assign in_ready_o = !vld_q || consume;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (consume) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  // Room check for each emission slot; the slots are monotonic, so the
  // number that fit is just the count of passing slots.
  assign cnt_ext = EXT_W'(cnt_q);
  assign lim_ext = EXT_W'(limit_i);

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      fits[k] = (cnt_ext + EXT_W'(k) < CNT_MAX) &&
                (cnt_ext + EXT_W'(k) + EXT_W'(2) <= lim_ext);
    end
    fit_n = RES_CNT_W'($countones(fits));
  end

  always_comb begin
    mode        = (mode_q > MODE_SKIP) ? MODE_SKIP : mode_q;
    is_end      = (byte_q == CHAR_NUL);
    parent_fail = 1'b0;
    opening     = 1'b0;
    dots        = 2'd0;
    req_n       = '0;
    mode_d      = mode;
    for (int i = 0; i < MAX_RES; i++) begin
      seq[i] = CHAR_SLASH;
    end

    if (is_end) begin
      if (mode == MODE_DOT2) begin
        parent_fail = 1'b1;
      end else if (mode != MODE_SKIP && cnt_q == '0) begin
        req_n = RES_CNT_W'(1);
      end
    end else begin
      unique case (mode)
        MODE_SEP: begin
          if (byte_q == CHAR_DOT) begin
            mode_d = MODE_DOT1;
          end else if (byte_q != CHAR_SLASH) begin
            opening = 1'b1;
          end
        end
        MODE_DOT1: begin
          if (byte_q == CHAR_SLASH) begin
            mode_d = MODE_SEP;
          end else if (byte_q == CHAR_DOT) begin
            mode_d = MODE_DOT2;
          end else begin
            opening = 1'b1;
            dots    = 2'd1;
          end
        end
        MODE_DOT2: begin
          if (byte_q == CHAR_SLASH) begin
            parent_fail = 1'b1;
          end else begin
            opening = 1'b1;
            dots    = 2'd2;
          end
        end
        MODE_SEG: begin
          if (byte_q == CHAR_SLASH) begin
            mode_d = MODE_SEP;
          end else begin
            req_n  = RES_CNT_W'(1);
            seq[0] = byte_q;
          end
        end
        default: begin
        end
      endcase
    end

    // A new segment goes out as the slash, any held-back dots, then the byte.
    if (opening) begin
      req_n  = RES_CNT_W'(dots) + RES_CNT_W'(2);
      seq[0] = CHAR_SLASH;
      seq[1] = (dots >= 2'd1) ? CHAR_DOT : byte_q;
      seq[2] = (dots >= 2'd2) ? CHAR_DOT : byte_q;
      seq[3] = byte_q;
      mode_d = MODE_SEG;
    end

    short_fit = (req_n > fit_n);
    emit_n    = short_fit ? fit_n : req_n;

    if (err_q != ERR_NONE) begin
      err_fin = err_q;
    end else if (parent_fail) begin
      err_fin = ERR_PARENT;
    end else if (short_fit) begin
      err_fin = ERR_LONG;
    end else begin
      err_fin = ERR_NONE;
    end

    err_d = err_q;
    cnt_d = cnt_q + COUNT_WIDTH'(emit_n);
    if (is_end) begin
      mode_d = MODE_SEP;
      err_d  = ERR_NONE;
      cnt_d  = '0;
    end else if (parent_fail || short_fit) begin
      mode_d = MODE_SKIP;
      err_d  = err_fin;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      push.res[i] = '0;
      if (RES_CNT_W'(i) < emit_n) begin
        push.res[i].out_byte   = seq[i];
        push.res[i].byte_valid = 1'b1;
      end else if (is_end && RES_CNT_W'(i) == emit_n) begin
        push.res[i].path_done = 1'b1;
        push.res[i].status    = err_fin;
      end
    end
    push.cnt = consume ? (emit_n + RES_CNT_W'(is_end)) : '0;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEP;
      err_q  <= ERR_NONE;
      cnt_q  <= '0;
    end else if (consume) begin
      mode_q <= mode_d;
      err_q  <= err_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // Once an error is latched, the rest of the path must be skipped.
  a_err_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |-> (mode_q == MODE_SKIP))
    else $error("error latched while not skipping");

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt <= RES_CNT_W'(MAX_RES))
    else $error("too many results for one byte");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && byte_q == CHAR_NUL) |=> (mode_q == MODE_SEP && cnt_q == '0))
    else $error("path state not cleared after end of path");
`endif

endmodule

// ----- rtl/pc_out_queue.sv -----
// Result queue: takes up to four results a cycle, delivers one a cycle while out_ready_i is high.
module pc_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pc_pkg::push_t        push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pc_pkg::result_t      out_res_o
);
  import pc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= CNT_W'(QUEUE_DEPTH - MAX_RES));
  assign out_res_o   = mem[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_i.cnt) begin
        mem[wr_ptr_q + PTR_W'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != '0) |-> (count_q <= CNT_W'(QUEUE_DEPTH - MAX_RES)))
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == PTR_W'(count_q))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- rtl/path_canonicalizer.sv -----
// Top level of the streaming path canonicalizer.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata[7:0] path_byte
//  m_axis    out  m_axis_tvalid/tready   tdata out_byte,status; tuser byte_valid;
//                                        tlast path_done
//  cfg       in   cfg_valid_i/ready_o    cfg_data_i length_limit
//
// A path byte is registered on acceptance and processed once the queue has room,
// which pushes zero to four results into an eight-entry result queue.
// The queue delivers one result per cycle while m_axis is ready, so the sustained
// rate is one result per cycle; input bytes that cause one result or none flow at one
// per cycle. A byte is held in the input register while the queue has fewer
// than four free entries, and a stalled m_axis side backs up to s_axis that way.
// Reset empties the queue, clears the parse state and sets length_limit to 1024.
module path_canonicalizer #(
  parameter int COUNT_WIDTH = pc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] path_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [7:0] out_byte, [9:8] status
  output logic                       m_axis_tuser,   // [0] byte_valid
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pc_pkg::LIMIT_W-1:0] cfg_data_i
);
  import pc_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               room;
  push_t              push;
  result_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  pc_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_byte_i (s_axis_tdata),
    .limit_i   (limit_q),
    .room_i    (room),
    .push_o    (push)
  );

  pc_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {6'b0, res.status, res.out_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.path_done;

endmodule

// ----- bench/tb_path_canonicalizer.sv -----
// Self-checking testbench for the streaming path canonicalizer.
module tb_path_canonicalizer;
  timeunit 1ns;
  timeprecision 1ps;

  import pc_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASE_BYTES  = 14;
  localparam logic [7:0]  END_BYTE     = 8'h00;
  localparam logic [7:0]  SLASH        = 8'h2F;
  localparam logic [7:0]  DOT          = 8'h2E;

  typedef enum logic [2:0] {AT_SEP, ONE_DOT, TWO_DOTS, IN_SEG, SKIPPING} seg_mode_e;
  typedef enum logic [1:0] {ST_OK, ST_PARENT, ST_TOO_LONG} status_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = '0;
  logic                m_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [LIMIT_W-1:0]  cfg_data = '0;

  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [15:0]         m_axis_tdata;   // [7:0] out_byte, [9:8] status
  logic                m_axis_tuser;   // [0] byte_valid
  logic                m_axis_tlast;
  logic                cfg_ready_o;

  // Model state of the canonicalizer.
  seg_mode_e           seg_mode;
  status_e             path_err;
  logic [12:0]         out_len;
  logic [LIMIT_W-1:0]  limit_q;

  logic [7:0]          path_stream[$];
  result_t             canon_expected[$];
  int                  bytes_queued = 0;
  int                  bytes_taken = 0;
  int                  errors = 0;
  int                  idle_cycles = 0;
  bit                  steady = 1'b0;

  path_canonicalizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_expected(logic [7:0] ch, logic valid, logic done,
                                       logic [1:0] st);
    result_t r;
    r.out_byte   = ch;
    r.byte_valid = valid;
    r.path_done  = done;
    r.status     = st;
    canon_expected.push_back(r);
  endfunction

  function automatic void clear_path();
    seg_mode = AT_SEP;
    path_err = ST_OK;
    out_len  = '0;
  endfunction

  function automatic void set_error(status_e code);
    if (path_err == ST_OK) path_err = code;
    seg_mode = SKIPPING;
  endfunction

  // A character fits only if the output plus its terminator stays within the limit.
  function automatic bit put_char(logic [7:0] ch);
    if (seg_mode == SKIPPING) return 1'b0;
    if (out_len == '1 || int'(out_len) + 2 > int'(limit_q)) begin
      set_error(ST_TOO_LONG);
      return 1'b0;
    end
    add_expected(ch, 1'b1, 1'b0, ST_OK);
    out_len = out_len + 1'b1;
    return 1'b1;
  endfunction

  // Dots held back at the start of a segment are released once it proves ordinary.
  function automatic void open_seg(int dots, logic [7:0] ch);
    if (!put_char(SLASH)) return;
    for (int i = 0; i < dots; i++)
      if (!put_char(DOT)) return;
    if (!put_char(ch)) return;
    seg_mode = IN_SEG;
  endfunction

  function automatic void canon_step(logic [7:0] b);
    if (b == END_BYTE) begin
      if (seg_mode == TWO_DOTS) set_error(ST_PARENT);
      if (seg_mode != SKIPPING && out_len == 0) void'(put_char(SLASH));
      add_expected(8'h00, 1'b0, 1'b1, path_err);
      clear_path();
      return;
    end
    case (seg_mode)
      AT_SEP: begin
        if (b == DOT) seg_mode = ONE_DOT;
        else if (b != SLASH) open_seg(0, b);
      end
      ONE_DOT: begin
        if (b == SLASH) seg_mode = AT_SEP;
        else if (b == DOT) seg_mode = TWO_DOTS;
        else open_seg(1, b);
      end
      TWO_DOTS: begin
        if (b == SLASH) set_error(ST_PARENT);
        else open_seg(2, b);
      end
      IN_SEG: begin
        if (b == SLASH) seg_mode = AT_SEP;
        else void'(put_char(b));
      end
      default: ;
    endcase
  endfunction

  task automatic queue_byte(logic [7:0] b);
    path_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_str(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] seg_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == SLASH) ? 8'h71 : c;
  endfunction

  // Mostly well-formed paths with random names; now and then raw noise.
  task automatic add_random_path();
    int nseg;
    int kind;
    int r;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(2);
        queue_byte(r == 0 ? SLASH : (r == 1 ? DOT : seg_char()));
      end
    end else begin
      nseg = $urandom_range(0, 4);
      for (int i = 0; i < nseg; i++) begin
        repeat ($urandom_range(i == 0 ? 0 : 1, 3)) queue_byte(SLASH);
        kind = $urandom_range(99);
        if (kind < 12) begin
          queue_byte(DOT);
        end else if (kind < 20) begin
          queue_byte(DOT);
          queue_byte(DOT);
        end else begin
          if (kind < 40) repeat ($urandom_range(1, 3)) queue_byte(DOT);
          repeat ($urandom_range(1, 6)) queue_byte(seg_char());
        end
      end
      if ($urandom_range(3) == 0) queue_byte(SLASH);
    end
    queue_byte(END_BYTE);
  endtask

  // Blocks until every queued byte is taken and every result has come back.
  task automatic drain();
    while (bytes_taken != bytes_queued || canon_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_q = v;
    cfg_valid <= 1'b0;
  endtask

  // Input side: one byte per transaction, with random gaps outside steady phases.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        canon_step(s_data);
        bytes_taken++;
      end
      if (!s_valid || s_axis_tready) begin
        if (path_stream.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          s_valid <= 1'b1;
          s_data  <= path_stream.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random backpressure outside steady phases and in-order comparison.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(99) >= 33);
      if (m_axis_tvalid && m_ready) begin
        got.out_byte   = m_axis_tdata[7:0];
        got.status     = m_axis_tdata[9:8];
        got.byte_valid = m_axis_tuser;
        got.path_done  = m_axis_tlast;
        if (canon_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result byte=%h valid=%b done=%b status=%0d",
                     $realtime, got.out_byte, got.byte_valid, got.path_done, got.status);
        end else begin
          want = canon_expected.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch (byte valid done status) exp %h %b %b %0d got %h %b %b %0d",
                       $realtime,
                       want.out_byte, want.byte_valid, want.path_done, want.status,
                       got.out_byte, got.byte_valid, got.path_done, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("path_canonicalizer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limits [10];
    int start;
    phase_limits = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd8191,
                     13'd6, 13'd4096, 13'd12, 13'd1024, 13'd40};
    limit_q = LIMIT_RESET;
    clear_path();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed paths under the reset limit: empty path, collapsing slashes and
    // dropped dot segments, held-back dots released by an ordinary byte, a parent
    // segment followed by more input, and a parent segment at the very end.
    queue_byte(END_BYTE);
    queue_str("//./a");
    queue_byte(8'hFF);
    queue_byte(END_BYTE);
    queue_str("/..");
    queue_byte(8'h80);
    queue_str("/.");
    queue_byte(END_BYTE);
    queue_str("x/../");
    queue_byte(8'h01);
    queue_byte(END_BYTE);
    queue_str("/..");
    queue_byte(END_BYTE);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_limit(phase_limits[ph]);
      steady = (ph == 4);
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) add_random_path();
      drain();
    end
    steady = 1'b0;

    if (errors == 0 && canon_expected.size() == 0) begin
      $display("path_canonicalizer test passed");
    end else begin
      $display("path_canonicalizer test failed");
    end
    $finish;
  end

endmodule
